FILE: src/belr_pkg.sv
// Package with the sizes, field widths and helper functions of the empty line removal core.
`timescale 1ns / 1ps
`default_nettype none
package belr_pkg;

	localparam int MAX_ROWS  = 8;
	localparam int MAX_COLS  = 8;
	localparam int MAX_DIM   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int ROW_W     = 3;
	localparam int COL_W     = 3;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(1);

	localparam logic [CFG_DAT_W-1:0] HEIGHT_RST = CFG_DAT_W'(6);
	localparam logic [CFG_DAT_W-1:0] WIDTH_RST  = CFG_DAT_W'(6);

	typedef logic [MAX_DIM-1:0] occ_t;

	// Returns the lowest set position of v, with a found flag in the top bit.
	function automatic logic [IDX_W:0] find_first(input occ_t v);
		logic [IDX_W:0] res;
		res = '0;
		for (int k = MAX_DIM - 1; k >= 0; k--) begin
			if (v[k]) begin
				res = {1'b1, IDX_W'(k)};
			end
		end
		return res;
	endfunction

	function automatic logic [CNT_W-1:0] count_set(input occ_t v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int k = 0; k < MAX_DIM; k++) begin
			n = n + CNT_W'(v[k]);
		end
		return n;
	endfunction

	// Clamps a configured size to the range one to limit.
	function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_DAT_W-1:0] v,
			input logic [CNT_W-1:0] limit);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (CNT_W'(v) > limit) begin
			r = limit;
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/belr_pix_if.sv
// Channel that carries one input pixel per word.
`timescale 1ns / 1ps
`default_nettype none
interface belr_pix_if;
	logic valid;
	logic ready;
	logic pixel_set;

	modport source (output valid, output pixel_set, input ready);
	modport sink (input valid, input pixel_set, output ready);
endinterface
`default_nettype wire

FILE: src/belr_res_if.sv
// Channel that carries one pixel of the compacted bitmap per word.
`timescale 1ns / 1ps
`default_nettype none
interface belr_res_if;
	logic                        valid;
	logic                        ready;
	logic                        out_pixel;
	logic [belr_pkg::ROW_W-1:0]  out_row;
	logic [belr_pkg::COL_W-1:0]  out_col;
	logic [belr_pkg::CNT_W-1:0]  kept_rows;
	logic [belr_pkg::CNT_W-1:0]  kept_cols;
	logic                        image_empty;
	logic                        last_of_image;

	modport source (output valid, output out_pixel, output out_row, output out_col,
		output kept_rows, output kept_cols, output image_empty, output last_of_image,
		input ready);
	modport sink (input valid, input out_pixel, input out_row, input out_col,
		input kept_rows, input kept_cols, input image_empty, input last_of_image,
		output ready);
endinterface
`default_nettype wire

FILE: src/belr_cfg_if.sv
// Register write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface belr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [belr_pkg::CFG_IDX_W-1:0] index;
	logic [belr_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/bitmap_empty_line_removal_core.sv
// Top level of the empty line removal core: row store, occupancy tracking and emission.
//
//   channel   dir   word
//   cfg       in    index (0 height, 1 width), data
//   pix_in    in    pixel_set, raster order
//   res_out   out   out_pixel, out_row, out_col, kept_rows, kept_cols,
//                   image_empty, last_of_image
//
// Pixels are taken while loading; a full row is written to the row store at once.
// After the final pixel, each kept row is read from the row store and then sent as one
// word per kept column; an empty image gives a single word marked image_empty.
// Pixels are not taken while an image is being emitted; a stalled result holds.
// Reset sets both sizes to six and clears the load position and occupancy bits.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_empty_line_removal_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	belr_cfg_if.sink    cfg,
	belr_pix_if.sink    pix_in,
	belr_res_if.source  res_out
);
	import belr_pkg::*;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_RD    = 2'd1;
	localparam logic [1:0] ST_PIX   = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	logic [1:0]           state_q;
	logic [CFG_DAT_W-1:0] height_q;
	logic [CFG_DAT_W-1:0] width_q;
	logic [ROW_W-1:0]     load_row_q;
	logic [COL_W-1:0]     load_col_q;
	occ_t                 row_occ_q;
	occ_t                 col_occ_q;
	logic [MAX_COLS-1:0]  row_buf_q;
	logic [CNT_W-1:0]     kr_q;
	logic [CNT_W-1:0]     kc_q;
	logic [IDX_W-1:0]     emit_row_q;
	logic [IDX_W-1:0]     emit_col_q;
	logic [ROW_W-1:0]     orow_q;
	logic [COL_W-1:0]     ocol_q;
	logic [MAX_COLS-1:0]  rd_data_s1;

	logic [MAX_COLS-1:0]  pixel_store [MAX_ROWS];

	logic                 out_valid_q;
	logic                 out_pixel_q;
	logic [ROW_W-1:0]     out_row_q;
	logic [COL_W-1:0]     out_col_q;
	logic [CNT_W-1:0]     out_kr_q;
	logic [CNT_W-1:0]     out_kc_q;
	logic                 out_empty_q;
	logic                 out_last_q;

	logic [CNT_W-1:0]     h_eff;
	logic [CNT_W-1:0]     w_eff;
	logic                 in_fire;
	logic                 cfg_fire;
	logic                 cfg_hit;
	logic                 out_free;
	logic                 row_end;
	logic                 img_end;
	logic [MAX_COLS-1:0]  row_wdata;
	occ_t                 row_occ_nxt;
	occ_t                 col_occ_nxt;
	logic [CNT_W-1:0]     kr_nxt;
	logic [IDX_W:0]       first_row;
	logic [IDX_W:0]       first_col;
	logic [IDX_W:0]       next_row;
	logic [IDX_W:0]       next_col;
	logic                 emit_pix;

	assign h_eff    = clamp_size(height_q, CNT_W'(MAX_ROWS));
	assign w_eff    = clamp_size(width_q, CNT_W'(MAX_COLS));
	assign in_fire  = pix_in.valid && pix_in.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign cfg_hit  = cfg_fire && (cfg.index == REG_HEIGHT || cfg.index == REG_WIDTH);
	assign out_free = !out_valid_q || res_out.ready;
	assign emit_pix = (state_q == ST_PIX) && out_free;

	assign pix_in.ready = (state_q == ST_LOAD);
	assign cfg.ready    = 1'b1;

	always_comb begin
		row_wdata             = row_buf_q;
		row_wdata[load_col_q] = pix_in.pixel_set;
		row_occ_nxt           = row_occ_q;
		col_occ_nxt           = col_occ_q;
		if (pix_in.pixel_set) begin
			row_occ_nxt[load_row_q] = 1'b1;
			col_occ_nxt[load_col_q] = 1'b1;
		end
		kr_nxt    = count_set(row_occ_nxt);
		row_end   = (CNT_W'(load_col_q) + CNT_W'(1)) == w_eff;
		img_end   = row_end && ((CNT_W'(load_row_q) + CNT_W'(1)) == h_eff);
		first_row = find_first(row_occ_nxt);
		first_col = find_first(col_occ_q);
		next_row  = find_first(row_occ_q & (occ_t'({MAX_DIM{1'b1}} << emit_row_q) << 1));
		next_col  = find_first(col_occ_q & (occ_t'({MAX_DIM{1'b1}} << emit_col_q) << 1));
	end

	// Row store: rows are written whole during loading and read only during emission.
	always_ff @(posedge clk) begin
		if (in_fire && row_end) begin
			pixel_store[load_row_q] <= row_wdata;
		end
		if (state_q == ST_RD) begin
			rd_data_s1 <= pixel_store[emit_row_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_buf_q <= row_wdata;
		end
		if (in_fire && img_end) begin
			kr_q       <= kr_nxt;
			kc_q       <= count_set(col_occ_nxt);
			emit_row_q <= first_row[IDX_W-1:0];
			orow_q     <= '0;
		end
		if (state_q == ST_RD) begin
			emit_col_q <= first_col[IDX_W-1:0];
			ocol_q     <= '0;
		end
		if (emit_pix) begin
			if (next_col[IDX_W]) begin
				emit_col_q <= next_col[IDX_W-1:0];
				ocol_q     <= ocol_q + COL_W'(1);
			end else begin
				emit_row_q <= next_row[IDX_W-1:0];
				orow_q     <= orow_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			height_q   <= HEIGHT_RST;
			width_q    <= WIDTH_RST;
			load_row_q <= '0;
			load_col_q <= '0;
			row_occ_q  <= '0;
			col_occ_q  <= '0;
		end else if (cfg_hit) begin
			if (cfg.index == REG_HEIGHT) begin
				height_q <= cfg.data;
			end else begin
				width_q <= cfg.data;
			end
			load_row_q <= '0;
			load_col_q <= '0;
			row_occ_q  <= '0;
			col_occ_q  <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						row_occ_q <= row_occ_nxt;
						col_occ_q <= col_occ_nxt;
						if (!row_end) begin
							load_col_q <= load_col_q + COL_W'(1);
						end else if (!img_end) begin
							load_col_q <= '0;
							load_row_q <= load_row_q + ROW_W'(1);
						end else begin
							load_col_q <= '0;
							load_row_q <= '0;
							state_q    <= (kr_nxt == '0) ? ST_EMPTY : ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_PIX;
				end
				ST_PIX: begin
					if (out_free && !next_col[IDX_W]) begin
						if (next_row[IDX_W]) begin
							state_q <= ST_RD;
						end else begin
							state_q   <= ST_LOAD;
							row_occ_q <= '0;
							col_occ_q <= '0;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output register: a word waits here while the next one is prepared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_pix || (state_q == ST_EMPTY && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_pix) begin
			out_pixel_q <= rd_data_s1[emit_col_q];
			out_row_q   <= orow_q;
			out_col_q   <= ocol_q;
			out_kr_q    <= kr_q;
			out_kc_q    <= kc_q;
			out_empty_q <= 1'b0;
			out_last_q  <= !next_col[IDX_W] && !next_row[IDX_W];
		end else if (state_q == ST_EMPTY && out_free) begin
			out_pixel_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_kr_q    <= '0;
			out_kc_q    <= '0;
			out_empty_q <= 1'b1;
			out_last_q  <= 1'b1;
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.out_pixel     = out_pixel_q;
	assign res_out.out_row       = out_row_q;
	assign res_out.out_col       = out_col_q;
	assign res_out.kept_rows     = out_kr_q;
	assign res_out.kept_cols     = out_kc_q;
	assign res_out.image_empty   = out_empty_q;
	assign res_out.last_of_image = out_last_q;

`ifndef ASSERT_OFF
	a_emit_pos_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX) |-> (row_occ_q[emit_row_q] && col_occ_q[emit_col_q]))
		else $error("emission points at an empty row or column");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.image_empty) |->
		(res_out.kept_rows == '0 && res_out.kept_cols == '0 && res_out.last_of_image))
		else $error("empty image word carries counts or no last mark");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && !res_out.image_empty) |->
		(CNT_W'(res_out.out_row) < res_out.kept_rows &&
		CNT_W'(res_out.out_col) < res_out.kept_cols))
		else $error("result coordinate outside the kept grid");

	a_stop_after_image: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && img_end && !cfg_hit) |=> !pix_in.ready)
		else $error("pixels taken while an image is being emitted");
`endif

endmodule
`default_nettype wire
